>>> hdl/tfsc_pkg.sv
// shared types, constants and calibration table of the thermistor fan speed controller
// no dependencies; imported by the interfaces, the top level and the checker
package tfsc_pkg;

    localparam int TABLE_POINTS = 10;
    localparam int TIDX_W       = $clog2(TABLE_POINTS);
    localparam int ADC_BITS_DEF = 10;
    localparam int CODE_W       = 16;
    localparam int DEG_W        = 6;
    localparam int PCT_W        = 7;
    localparam int PWM_W        = 16;
    localparam int MS_W         = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int MUL_A_W      = PWM_W + 1;
    localparam int MUL_B_W      = PCT_W;
    localparam int DIV_W        = MUL_A_W + MUL_B_W;

    // reciprocal of 100 scaled by 2^31, exact for any 24-bit dividend
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 31;
    localparam logic [RECIP_W-1:0] PCT_RECIP = 25'd21474837;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    localparam logic [CODE_W-1:0] CAL_CODE [TABLE_POINTS] =
        '{16'd350, 16'd396, 16'd455, 16'd489, 16'd512,
          16'd541, 16'd568, 16'd595, 16'd620, 16'd668};
    localparam logic [DEG_W-1:0] CAL_DEG [TABLE_POINTS] =
        '{6'd10, 6'd15, 6'd20, 6'd24, 6'd25, 6'd28, 6'd30, 6'd32, 6'd35, 6'd40};

    localparam logic [DEG_W-1:0] TEMP_MIN = CAL_DEG[0];
    localparam logic [DEG_W-1:0] TEMP_MAX = CAL_DEG[TABLE_POINTS-1];

    localparam logic [PWM_W-1:0] PWM_PERIOD_RST    = 16'd999;
    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd100;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd40;
    localparam logic [DEG_W-1:0] TEMP_LOW_RST      = 6'd24;
    localparam logic [DEG_W-1:0] TEMP_MID_RST      = 6'd28;
    localparam logic [DEG_W-1:0] TEMP_HIGH_RST     = 6'd32;
    localparam logic [PCT_W-1:0] LOW_DUTY_RST      = 7'd35;
    localparam logic [PCT_W-1:0] MID_DUTY_RST      = 7'd65;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD,
        CFG_SAMPLE_PERIOD,
        CFG_DEBOUNCE,
        CFG_TEMP_LOW,
        CFG_TEMP_MID,
        CFG_TEMP_HIGH,
        CFG_LOW_DUTY,
        CFG_MID_DUTY
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_TICK,
        ACT_BUTTON,
        ACT_SAMPLE
    } action_t;

endpackage

>>> hdl/tfsc_if.sv
// valid/ready channel interfaces: event transactions in, status transactions out
// depends on tfsc_pkg
interface tfsc_req_if import tfsc_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) ();
    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic                button_level;
    logic [ADC_BITS-1:0] sample_value;

    modport source (output valid, action, button_level, sample_value, input ready);
    modport sink   (input valid, action, button_level, sample_value, output ready);
endinterface

interface tfsc_rsp_if import tfsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PWM_W-1:0] duty_ticks;
    logic             manual_mode;
    logic             sample_request;
    logic [DEG_W-1:0] temperature;

    modport source (output valid, duty_ticks, manual_mode, sample_request, temperature,
                    input ready);
    modport sink   (input valid, duty_ticks, manual_mode, sample_request, temperature,
                    output ready);
endinterface

>>> hdl/tfsc_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on nothing but its parameters
module tfsc_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = shifted - {1'b0, den_reg};
        fits      = (shifted >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
            cnt_next = CNT_W'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/thermistor_fan_speed_controller.sv
// thermistor fan speed controller top level: sequencer, state and configuration registers
// depends on tfsc_pkg, tfsc_if and tfsc_div
//
// usage
// - req channel carries one event per transaction: a 1 ms tick, a button edge with
//   its pin level, or an adc sample; rsp channel returns exactly one status
//   transaction per event (duty, mode, sample request, last temperature)
// - configuration: cfg_we with cfg_index and cfg_data writes one register; write
//   only while no event is in flight
// - tick, button and unused codes go from dispatch straight to the result; a
//   manual sample scales the adc code to a percent and then to duty ticks
// - an auto sample walks the calibration table one point per cycle (up to 10) and,
//   between two points, interpolates with one serial division of dividend width;
//   percent and duty scaling use a shift-add and a reciprocal multiply
// - one event at a time: req.ready is high only while the sequencer is idle
// - the result sits in an output register; the next event is accepted while it
//   waits, and a stalled receiver holds the sequencer at its last step
// - reset: auto mode, duty zero, temperature zero, sample request set, counters
//   cleared, registers at their default values
module thermistor_fan_speed_controller import tfsc_pkg::*; #(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    tfsc_req_if.sink             req,
    tfsc_rsp_if.source           rsp
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_WALK,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SCALE,
        ST_CLAMP,
        ST_THRESH,
        ST_PCT,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PUR_INTERP,
        PUR_MANUAL,
        PUR_DUTY
    } purpose_t;

    // configuration registers
    logic [PWM_W-1:0] pwm_period_reg;
    logic [CFG_W-1:0] sample_period_reg;
    logic [CFG_W-1:0] debounce_reg;
    logic [DEG_W-1:0] temp_low_reg;
    logic [DEG_W-1:0] temp_mid_reg;
    logic [DEG_W-1:0] temp_high_reg;
    logic [PCT_W-1:0] low_duty_reg;
    logic [PCT_W-1:0] mid_duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg    <= PWM_PERIOD_RST;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            debounce_reg      <= DEBOUNCE_RST;
            temp_low_reg      <= TEMP_LOW_RST;
            temp_mid_reg      <= TEMP_MID_RST;
            temp_high_reg     <= TEMP_HIGH_RST;
            low_duty_reg      <= LOW_DUTY_RST;
            mid_duty_reg      <= MID_DUTY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PWM_PERIOD:    pwm_period_reg    <= cfg_data;
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                CFG_DEBOUNCE:      debounce_reg      <= cfg_data;
                CFG_TEMP_LOW:      temp_low_reg      <= cfg_data[DEG_W-1:0];
                CFG_TEMP_MID:      temp_mid_reg      <= cfg_data[DEG_W-1:0];
                CFG_TEMP_HIGH:     temp_high_reg     <= cfg_data[DEG_W-1:0];
                CFG_LOW_DUTY:      low_duty_reg      <= cfg_data[PCT_W-1:0];
                CFG_MID_DUTY:      mid_duty_reg      <= cfg_data[PCT_W-1:0];
                default:           pwm_period_reg    <= pwm_period_reg;
            endcase
        end
    end

    state_t              state_reg, state_next;
    logic [1:0]          action_reg, action_next;
    logic                level_reg, level_next;
    logic [ADC_BITS-1:0] sample_reg, sample_next;
    logic [MS_W-1:0]     ms_reg, ms_next;
    logic [MS_W-1:0]     press_reg, press_next;
    logic [CFG_W-1:0]    sdiv_reg, sdiv_next;
    logic                mode_reg, mode_next;
    logic                pending_reg, pending_next;
    logic [PWM_W-1:0]    duty_reg, duty_next;
    logic [DEG_W-1:0]    temp_reg, temp_next;
    logic [TIDX_W-1:0]   idx_reg, idx_next;
    logic [DEG_W-1:0]    y0_reg, y0_next;
    logic [PCT_W-1:0]    pct_reg, pct_next;
    logic [MUL_A_W-1:0]  mul_a_reg, mul_a_next;
    logic [MUL_B_W-1:0]  mul_b_reg, mul_b_next;
    logic [DIV_W-1:0]    prod_reg, prod_next;
    logic [ADC_BITS-1:0] den_reg, den_next;
    purpose_t            purpose_reg, purpose_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [PWM_W-1:0]    rsp_duty_reg, rsp_duty_next;
    logic                rsp_mode_reg, rsp_mode_next;
    logic                rsp_pending_reg, rsp_pending_next;
    logic [DEG_W-1:0]    rsp_temp_reg, rsp_temp_next;

    logic              div_start;
    logic              div_done;
    logic [DIV_W-1:0]  div_quotient;

    logic [CFG_W-1:0]  sdiv_inc;
    logic [MS_W-1:0]   press_gap;
    logic [TIDX_W-1:0] idx_prev;
    logic [CODE_W-1:0] sample_ext;
    logic [CODE_W-1:0] x0;
    logic [CODE_W-1:0] x1;
    logic [CODE_W-1:0] dx;
    logic [CODE_W-1:0] dcode;
    logic [DEG_W-1:0]  dy;

    logic [DIV_W-1:0]         scale_sum;
    logic [DIV_W+RECIP_W-1:0] recip_prod;

    tfsc_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (ADC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign div_start = (state_reg == ST_DIV_GO);

    always_comb
    begin
        sdiv_inc   = sdiv_reg + 1'b1;
        press_gap  = ms_reg - press_reg;
        idx_prev   = idx_reg - 1'b1;
        sample_ext = CODE_W'(sample_reg);
        x1         = CAL_CODE[idx_reg];
        x0         = CAL_CODE[idx_prev];
        dx         = sample_ext - x0;
        dcode      = x1 - x0;
        dy         = CAL_DEG[idx_reg] - CAL_DEG[idx_prev];
        // divide by full scale 2^n - 1 as a shift-add, exact while the quotient stays small
        scale_sum  = prod_reg + (prod_reg >> ADC_BITS) + 1'b1;
        recip_prod = prod_reg * PCT_RECIP;

        state_next       = state_reg;
        action_next      = action_reg;
        level_next       = level_reg;
        sample_next      = sample_reg;
        ms_next          = ms_reg;
        press_next       = press_reg;
        sdiv_next        = sdiv_reg;
        mode_next        = mode_reg;
        pending_next     = pending_reg;
        duty_next        = duty_reg;
        temp_next        = temp_reg;
        idx_next         = idx_reg;
        y0_next          = y0_reg;
        pct_next         = pct_reg;
        mul_a_next       = mul_a_reg;
        mul_b_next       = mul_b_reg;
        prod_next        = prod_reg;
        den_next         = den_reg;
        purpose_next     = purpose_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_duty_next    = rsp_duty_reg;
        rsp_mode_next    = rsp_mode_reg;
        rsp_pending_next = rsp_pending_reg;
        rsp_temp_next    = rsp_temp_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    action_next = req.action;
                    level_next  = req.button_level;
                    sample_next = req.sample_value;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = ST_FINISH;
                case (action_t'(action_reg))
                    ACT_TICK:
                    begin
                        ms_next   = ms_reg + 1'b1;
                        sdiv_next = sdiv_inc;
                        if (sdiv_inc >= sample_period_reg)
                        begin
                            sdiv_next    = '0;
                            pending_next = 1'b1;
                        end
                    end
                    ACT_BUTTON:
                    begin
                        if (press_gap >= MS_W'(debounce_reg))
                        begin
                            press_next = ms_reg;
                            if (!level_reg)
                            begin
                                mode_next    = !mode_reg;
                                pending_next = 1'b1;
                            end
                        end
                    end
                    ACT_SAMPLE:
                    begin
                        pending_next = 1'b0;
                        if (mode_reg)
                        begin
                            mul_a_next   = MUL_A_W'(sample_reg);
                            mul_b_next   = PCT_FULL;
                            purpose_next = PUR_MANUAL;
                            state_next   = ST_MUL;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = ST_WALK;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_WALK:
            begin
                if (sample_ext <= x1)
                begin
                    if (idx_reg == '0)
                    begin
                        temp_next  = CAL_DEG[0];
                        state_next = ST_THRESH;
                    end
                    else
                    begin
                        y0_next      = CAL_DEG[idx_prev];
                        mul_a_next   = MUL_A_W'(dx);
                        mul_b_next   = MUL_B_W'(dy);
                        den_next     = ADC_BITS'(dcode);
                        purpose_next = PUR_INTERP;
                        state_next   = ST_MUL;
                    end
                end
                else if (idx_reg == TIDX_W'(TABLE_POINTS - 1))
                begin
                    temp_next  = TEMP_MAX;
                    state_next = ST_THRESH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                prod_next = mul_a_reg * mul_b_reg;
                if (purpose_reg == PUR_INTERP)
                    state_next = ST_DIV_GO;
                else
                    state_next = ST_SCALE;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    temp_next  = y0_reg + div_quotient[DEG_W-1:0];
                    state_next = ST_THRESH;
                end
            end
            ST_SCALE:
            begin
                if (purpose_reg == PUR_MANUAL)
                begin
                    pct_next   = PCT_W'(scale_sum >> ADC_BITS);
                    state_next = ST_PCT;
                end
                else
                begin
                    prod_next  = DIV_W'(recip_prod >> RECIP_SHIFT);
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                if (prod_reg > DIV_W'(pwm_period_reg))
                    duty_next = pwm_period_reg;
                else
                    duty_next = prod_reg[PWM_W-1:0];
                state_next = ST_FINISH;
            end
            ST_THRESH:
            begin
                if (temp_reg < temp_low_reg)
                    pct_next = '0;
                else if (temp_reg < temp_mid_reg)
                    pct_next = low_duty_reg;
                else if (temp_reg < temp_high_reg)
                    pct_next = mid_duty_reg;
                else
                    pct_next = PCT_FULL;
                state_next = ST_PCT;
            end
            ST_PCT:
            begin
                if (pct_reg >= PCT_FULL)
                begin
                    duty_next  = pwm_period_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    mul_a_next   = MUL_A_W'(pwm_period_reg) + 1'b1;
                    mul_b_next   = pct_reg;
                    purpose_next = PUR_DUTY;
                    state_next   = ST_MUL;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_duty_next    = duty_reg;
                    rsp_mode_next    = mode_reg;
                    rsp_pending_next = pending_reg;
                    rsp_temp_next    = temp_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            action_reg      <= '0;
            level_reg       <= 1'b1;
            sample_reg      <= '0;
            ms_reg          <= '0;
            press_reg       <= '0;
            sdiv_reg        <= '0;
            mode_reg        <= 1'b0;
            pending_reg     <= 1'b1;
            duty_reg        <= '0;
            temp_reg        <= '0;
            idx_reg         <= '0;
            y0_reg          <= '0;
            pct_reg         <= '0;
            mul_a_reg       <= '0;
            mul_b_reg       <= '0;
            prod_reg        <= '0;
            den_reg         <= '0;
            purpose_reg     <= PUR_INTERP;
            rsp_valid_reg   <= 1'b0;
            rsp_duty_reg    <= '0;
            rsp_mode_reg    <= 1'b0;
            rsp_pending_reg <= 1'b0;
            rsp_temp_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            action_reg      <= action_next;
            level_reg       <= level_next;
            sample_reg      <= sample_next;
            ms_reg          <= ms_next;
            press_reg       <= press_next;
            sdiv_reg        <= sdiv_next;
            mode_reg        <= mode_next;
            pending_reg     <= pending_next;
            duty_reg        <= duty_next;
            temp_reg        <= temp_next;
            idx_reg         <= idx_next;
            y0_reg          <= y0_next;
            pct_reg         <= pct_next;
            mul_a_reg       <= mul_a_next;
            mul_b_reg       <= mul_b_next;
            prod_reg        <= prod_next;
            den_reg         <= den_next;
            purpose_reg     <= purpose_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_duty_reg    <= rsp_duty_next;
            rsp_mode_reg    <= rsp_mode_next;
            rsp_pending_reg <= rsp_pending_next;
            rsp_temp_reg    <= rsp_temp_next;
        end
    end

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.duty_ticks     = rsp_duty_reg;
    assign rsp.manual_mode    = rsp_mode_reg;
    assign rsp.sample_request = rsp_pending_reg;
    assign rsp.temperature    = rsp_temp_reg;

endmodule

>>> hdl/tfsc_chk.sv
// port-level checker for the thermistor fan speed controller, bound to the top level
// depends on tfsc_pkg and thermistor_fan_speed_controller
module tfsc_chk import tfsc_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [PWM_W-1:0] rsp_duty_ticks,
    input logic             rsp_manual_mode,
    input logic             rsp_sample_request,
    input logic [DEG_W-1:0] rsp_temperature
);

    // stalled result stays
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_duty_ticks) && $stable(rsp_manual_mode)
            && $stable(rsp_sample_request) && $stable(rsp_temperature))
        else $error("result payload changed while stalled");

    // one transaction in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("event accepted while busy");

    // temperature is zero before the first auto sample, else within the table
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_temperature == '0)
            || ((rsp_temperature >= TEMP_MIN) && (rsp_temperature <= TEMP_MAX)))
        else $error("temperature outside calibration range");

endmodule

bind thermistor_fan_speed_controller tfsc_chk u_tfsc_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_duty_ticks     (rsp.duty_ticks),
    .rsp_manual_mode    (rsp.manual_mode),
    .rsp_sample_request (rsp.sample_request),
    .rsp_temperature    (rsp.temperature)
);
